### rtl/nnis_pkg.sv
package nnis_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;

  localparam int unsigned PIX_W = 32;
  localparam int unsigned DIM_W = 9;
  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned SIZE_W      = 2 * DIM_W;

  localparam int unsigned CNT_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned DVD_W = CNT_W + DIM_W;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              last;
  } fetch_t;

  // A zero dimension acts as one and a large one saturates at the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

### rtl/nnis_ram.sv
module nnis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/nnis_div.sv
module nnis_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [nnis_pkg::DVD_W-1:0]  dividend_i,
  input  logic [nnis_pkg::DIM_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [nnis_pkg::DVD_W-1:0]  quotient_o,
  output logic [nnis_pkg::DIM_W-1:0]  remainder_o
);
  import nnis_pkg::*;

  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DIM_W-1:0]  rem_q, rem_d;
  logic [DIM_W-1:0]  dvs_q;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [DIM_W:0]    shifted;
  logic [DIM_W:0]    trial;

  always_comb begin
    shifted = {rem_q, quo_q[DVD_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = STEP_W'(DVD_W);
    end else if (cnt_q != '0) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = trial[DIM_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DIM_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

### rtl/nnis_scan.sv
module nnis_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       restart_i,
  input  logic [nnis_pkg::DIM_W-1:0] src_w_i,
  input  logic [nnis_pkg::DIM_W-1:0] src_h_i,
  input  logic [nnis_pkg::DIM_W-1:0] dst_w_i,
  input  logic [nnis_pkg::DIM_W-1:0] dst_h_i,
  input  logic                       step_i,
  output logic                       busy_o,
  output nnis_pkg::fetch_t           fetch_o
);
  import nnis_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QX,
    S_SX,
    S_QY,
    S_SY
  } state_e;

  state_e           state_q;
  logic             wait_q;
  logic [COL_W-1:0] col_q, col_d, col_eff;
  logic [ROW_W-1:0] row_q, row_d, row_eff;
  logic [COL_W-1:0] sx_q, sx_d;
  logic [ROW_W-1:0] sy_q, sy_d;
  logic [DIM_W-1:0] ex_q, ex_d, ey_q, ey_d;
  logic [DIM_W-1:0] qx_q, rx_q, qy_q, ry_q;

  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dividend, div_quo;
  logic [DIM_W-1:0] div_divisor, div_rem;

  logic [DIM_W:0]          ex_sum, ey_sum;
  logic                    ex_carry, ey_carry;
  logic [DIM_W:0]          sx_sum;
  logic [DIM_W:0]          sy_sum;
  logic [ROW_W+DIM_W-1:0]  row_base;
  logic [ROW_W+DIM_W:0]    addr_full;
  logic                    col_end, row_end;

  assign col_eff = ({{(DIM_W-COL_W){1'b0}}, col_q} >= dst_w_i) ? '0 : col_q;
  assign row_eff = ({{(DIM_W-ROW_W){1'b0}}, row_q} >= dst_h_i) ? '0 : row_q;

  always_comb begin
    div_divisor  = dst_w_i;
    div_dividend = DVD_W'(src_w_i);
    unique case (state_q)
      S_QX: begin
        div_divisor  = dst_w_i;
        div_dividend = DVD_W'(src_w_i);
      end
      S_SX: begin
        div_divisor  = dst_w_i;
        div_dividend = DVD_W'(col_eff) * DVD_W'(src_w_i);
      end
      S_QY: begin
        div_divisor  = dst_h_i;
        div_dividend = DVD_W'(src_h_i);
      end
      S_SY: begin
        div_divisor  = dst_h_i;
        div_dividend = DVD_W'(row_eff) * DVD_W'(src_h_i);
      end
      default: begin
        div_divisor  = dst_w_i;
        div_dividend = DVD_W'(src_w_i);
      end
    endcase
  end

  assign div_start = !restart_i && (state_q != S_IDLE) && !wait_q;

  nnis_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Source column and row advance by quotient and remainder of the scale ratio.
  always_comb begin
    col_end  = ((DIM_W+1)'(col_eff) + (DIM_W+1)'(1)) >= {1'b0, dst_w_i};
    row_end  = ((DIM_W+1)'(row_eff) + (DIM_W+1)'(1)) >= {1'b0, dst_h_i};
    ex_sum   = {1'b0, ex_q} + {1'b0, rx_q};
    ex_carry = ex_sum >= {1'b0, dst_w_i};
    ey_sum   = {1'b0, ey_q} + {1'b0, ry_q};
    ey_carry = ey_sum >= {1'b0, dst_h_i};
    sx_sum   = (DIM_W+1)'(sx_q) + {1'b0, qx_q} + (DIM_W+1)'(ex_carry);
    sy_sum   = (DIM_W+1)'(sy_q) + {1'b0, qy_q} + (DIM_W+1)'(ey_carry);

    col_d = col_eff;
    row_d = row_eff;
    sx_d  = sx_q;
    ex_d  = ex_q;
    sy_d  = sy_q;
    ey_d  = ey_q;
    if (col_end) begin
      col_d = '0;
      sx_d  = '0;
      ex_d  = '0;
      if (row_end) begin
        row_d = '0;
        sy_d  = '0;
        ey_d  = '0;
      end else begin
        row_d = row_eff + ROW_W'(1);
        sy_d  = sy_sum[ROW_W-1:0];
        ey_d  = ey_carry ? DIM_W'(ey_sum - {1'b0, dst_h_i}) : ey_sum[DIM_W-1:0];
      end
    end else begin
      col_d = col_eff + COL_W'(1);
      sx_d  = sx_sum[COL_W-1:0];
      ex_d  = ex_carry ? DIM_W'(ex_sum - {1'b0, dst_w_i}) : ex_sum[DIM_W-1:0];
    end
  end

  assign row_base     = (ROW_W+DIM_W)'(sy_q) * (ROW_W+DIM_W)'(src_w_i);
  assign addr_full    = {1'b0, row_base} + (ROW_W+DIM_W+1)'(sx_q);
  assign fetch_o.addr = addr_full[ADDR_W-1:0];
  assign fetch_o.last = (DIM_W'(row_eff) == (dst_h_i - DIM_W'(1))) &&
                        (DIM_W'(col_eff) == (dst_w_i - DIM_W'(1)));
  assign busy_o       = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_QX;
      wait_q  <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      ex_q    <= '0;
      ey_q    <= '0;
      qx_q    <= '0;
      rx_q    <= '0;
      qy_q    <= '0;
      ry_q    <= '0;
    end else if (restart_i) begin
      state_q <= S_QX;
      wait_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (step_i) begin
            col_q <= col_d;
            row_q <= row_d;
            sx_q  <= sx_d;
            ex_q  <= ex_d;
            sy_q  <= sy_d;
            ey_q  <= ey_d;
          end
        end
        S_QX, S_SX, S_QY, S_SY: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (div_done) begin
            wait_q <= 1'b0;
            unique case (state_q)
              S_QX: begin
                qx_q    <= div_quo[DIM_W-1:0];
                rx_q    <= div_rem;
                state_q <= S_SX;
              end
              S_SX: begin
                sx_q    <= div_quo[COL_W-1:0];
                ex_q    <= div_rem;
                state_q <= S_QY;
              end
              S_QY: begin
                qy_q    <= div_quo[DIM_W-1:0];
                ry_q    <= div_rem;
                state_q <= S_SY;
              end
              default: begin
                sy_q    <= div_quo[ROW_W-1:0];
                ey_q    <= div_rem;
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        default: begin
          state_q <= S_QX;
        end
      endcase
    end
  end

endmodule

### rtl/nearest_neighbor_image_scaler_top.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   command_i, pixel_in_i
// out      output     out_valid_o / out_ready_i pixel_out_o, last_of_frame_o
// cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// Loads and fetches are taken one per cycle while in_ready_o is high; a fetched
// pixel passes the registered read of the frame store, then the output queue.
// After reset and after every configuration write, the divider recomputes the
// scale ratios and source positions, and no transaction is taken meanwhile.
// A two-entry output queue keeps one fetch per cycle flowing while out_ready_i
// is high; the input stalls when the queue and the read in flight fill it.
module nearest_neighbor_image_scaler_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic [nnis_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [nnis_pkg::PIX_W-1:0]     pixel_out_o,
  output logic                           last_of_frame_o,
  input  logic                           cfg_we_i,
  input  logic [nnis_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nnis_pkg::DIM_W-1:0]     cfg_data_i
);
  import nnis_pkg::*;

  logic [DIM_W-1:0]  src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] load_idx_q, load_cur;
  logic [SIZE_W-1:0] load_nxt;
  logic              busy;
  fetch_t            fetch;
  logic              accept, do_load, do_fetch;

  logic [PIX_W-1:0]  rdata;
  logic              rd_pend_q;
  logic              rd_last_q;
  logic [PIX_W-1:0]  q_data_q [2];
  logic              q_last_q [2];
  logic              q_head_q;
  logic [1:0]        q_cnt_q;
  logic              pop;
  logic [1:0]        occ;
  logic              q_wptr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DIM_W'(MAX_WIDTH);
      src_h_q <= DIM_W'(MAX_HEIGHT);
      dst_w_q <= DIM_W'(MAX_WIDTH);
      dst_h_q <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SRC_WIDTH:  src_w_q <= clamp_dim(cfg_data_i, DIM_W'(MAX_WIDTH));
        REG_SRC_HEIGHT: src_h_q <= clamp_dim(cfg_data_i, DIM_W'(MAX_HEIGHT));
        REG_DST_WIDTH:  dst_w_q <= clamp_dim(cfg_data_i, DIM_W'(MAX_WIDTH));
        REG_DST_HEIGHT: dst_h_q <= clamp_dim(cfg_data_i, DIM_W'(MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    size_q <= SIZE_W'(src_w_q) * SIZE_W'(src_h_q);
  end

  nnis_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .src_w_i   (src_w_q),
    .src_h_i   (src_h_q),
    .dst_w_i   (dst_w_q),
    .dst_h_i   (dst_h_q),
    .step_i    (do_fetch),
    .busy_o    (busy),
    .fetch_o   (fetch)
  );

  assign pop        = out_valid_o && out_ready_i;
  assign occ        = q_cnt_q + 2'(rd_pend_q);
  assign in_ready_o = !busy && !cfg_we_i && ((occ < 2'd2) || pop);
  assign accept     = in_valid_i && in_ready_o;
  assign do_load    = accept && !command_i;
  assign do_fetch   = accept && command_i;

  assign load_cur = ({{(SIZE_W-ADDR_W){1'b0}}, load_idx_q} >= size_q) ? '0 : load_idx_q;
  assign load_nxt = SIZE_W'(load_cur) + SIZE_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_idx_q <= '0;
    end else if (do_load) begin
      load_idx_q <= (load_nxt >= size_q) ? '0 : load_nxt[ADDR_W-1:0];
    end
  end

  nnis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_load),
    .waddr_i (load_cur),
    .wdata_i (pixel_in_i),
    .re_i    (do_fetch),
    .raddr_i (fetch.addr),
    .rdata_o (rdata)
  );

  assign q_wptr = q_head_q ^ q_cnt_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      q_head_q  <= 1'b0;
      q_cnt_q   <= '0;
    end else begin
      rd_pend_q <= do_fetch;
      if (pop) begin
        q_head_q <= ~q_head_q;
      end
      q_cnt_q <= q_cnt_q + 2'(rd_pend_q) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_last_q <= fetch.last;
    if (rd_pend_q) begin
      q_data_q[q_wptr] <= rdata;
      q_last_q[q_wptr] <= rd_last_q;
    end
  end

  assign out_valid_o     = (q_cnt_q != '0);
  assign pixel_out_o     = q_data_q[q_head_q];
  assign last_of_frame_o = q_last_q[q_head_q];

endmodule

### verif/nnis_tb_pkg.sv
`timescale 1ns / 1ps
package nnis_tb_pkg;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } scaler_cmd_e;

  // A dimension written as zero acts as one, and one above the limit saturates.
  function automatic int unsigned effective_dim(input int unsigned raw,
                                                input int unsigned limit);
    int unsigned v;
    v = raw & 32'h1FF;
    if (v == 0) begin
      return 1;
    end
    if (v > limit) begin
      return limit;
    end
    return v;
  endfunction

endpackage

### verif/nnis_scale_checker.sv
`timescale 1ns / 1ps
module nnis_scale_checker
  import nnis_pkg::*;
  import nnis_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 command_i,
  input  logic [PIX_W-1:0]     pixel_in_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [PIX_W-1:0]     pixel_out_i,
  input  logic                 last_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } scaled_pixel_t;

  logic [PIX_W-1:0] frame_copy [STORE_DEPTH];
  int unsigned      dims [4];
  int unsigned      load_pos;
  int unsigned      col;
  int unsigned      row;
  int unsigned      errors;
  scaled_pixel_t    due_pixels [$];

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned   frame_pixels;
    int unsigned   sy;
    int unsigned   sx;
    scaled_pixel_t want;
    if (!rst_ni) begin
      dims = '{MAX_WIDTH, MAX_HEIGHT, MAX_WIDTH, MAX_HEIGHT};
      load_pos = 0;
      col = 0;
      row = 0;
      errors = 0;
      due_pixels.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_pixels.size() == 0) begin
          $error("pixel_out: no pixel expected, actual %08h", pixel_out_i);
          errors++;
        end else begin
          want = due_pixels.pop_front();
          if (pixel_out_i !== want.pixel) begin
            $error("pixel_out: expected %08h actual %08h", want.pixel, pixel_out_i);
            errors++;
          end
          if (last_i !== want.last) begin
            $error("last_of_frame: expected %0b actual %0b", want.last, last_i);
            errors++;
          end
        end
      end
      if (cfg_we_i) begin
        dims[cfg_index_i] = effective_dim(cfg_data_i,
            (cfg_index_i == REG_SRC_WIDTH || cfg_index_i == REG_DST_WIDTH) ?
            MAX_WIDTH : MAX_HEIGHT);
      end
      if (in_valid_i && in_ready_i) begin
        if (command_i == CMD_LOAD) begin
          frame_pixels = dims[REG_SRC_WIDTH] * dims[REG_SRC_HEIGHT];
          if (load_pos >= frame_pixels) begin
            load_pos = 0;
          end
          frame_copy[load_pos] = pixel_in_i;
          load_pos++;
          if (load_pos >= frame_pixels) begin
            load_pos = 0;
          end
        end else begin
          if (col >= dims[REG_DST_WIDTH]) begin
            col = 0;
          end
          if (row >= dims[REG_DST_HEIGHT]) begin
            row = 0;
          end
          sy = row * dims[REG_SRC_HEIGHT] / dims[REG_DST_HEIGHT];
          sx = col * dims[REG_SRC_WIDTH] / dims[REG_DST_WIDTH];
          want.pixel = frame_copy[sy * dims[REG_SRC_WIDTH] + sx];
          want.last = (row == dims[REG_DST_HEIGHT] - 1) && (col == dims[REG_DST_WIDTH] - 1);
          due_pixels.push_back(want);
          col++;
          if (col >= dims[REG_DST_WIDTH]) begin
            col = 0;
            row++;
            if (row >= dims[REG_DST_HEIGHT]) begin
              row = 0;
            end
          end
        end
      end
    end
    mismatch_count_o <= errors;
    pending_o <= due_pixels.size();
  end

endmodule

### verif/tb_nearest_neighbor_image_scaler_top.sv
`timescale 1ns / 1ps
module tb_nearest_neighbor_image_scaler_top;
  import nnis_pkg::*;
  import nnis_tb_pkg::*;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } rx_pattern_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 command = 1'b0;
  logic [PIX_W-1:0]     pixel_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     pixel_out;
  logic                 last_of_frame;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  int unsigned          mismatches;
  int unsigned          pending;

  // Stimulus-side view of the store, so that no fetch reads an entry never loaded.
  int unsigned dim_now [4] = '{MAX_WIDTH, MAX_HEIGHT, MAX_WIDTH, MAX_HEIGHT};
  int unsigned loaded_pos = 0;
  int unsigned loaded_hi = 0;
  int unsigned next_col = 0;
  int unsigned next_row = 0;

  nearest_neighbor_image_scaler_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .command_i       (command),
    .pixel_in_i      (pixel_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .pixel_out_o     (pixel_out),
    .last_of_frame_o (last_of_frame),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  nnis_scale_checker u_scale_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .command_i        (command),
    .pixel_in_i       (pixel_in),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .pixel_out_i      (pixel_out),
    .last_i           (last_of_frame),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rx_pattern_e pattern;
    int unsigned span;
    forever begin
      pattern = rx_pattern_e'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        case (pattern)
          RX_OPEN: begin
            out_ready <= 1'b1;
          end
          RX_COIN: begin
            out_ready <= ($urandom_range(0, 1) == 1);
          end
          RX_SPARSE: begin
            out_ready <= ($urandom_range(0, 4) == 0);
          end
          default: begin
            out_ready <= ~out_ready;
          end
        endcase
      end
    end
  end

  // Source address that the next fetch will read.
  function automatic int unsigned fetch_source();
    int unsigned c;
    int unsigned r;
    c = (next_col >= dim_now[REG_DST_WIDTH]) ? 0 : next_col;
    r = (next_row >= dim_now[REG_DST_HEIGHT]) ? 0 : next_row;
    return (r * dim_now[REG_SRC_HEIGHT] / dim_now[REG_DST_HEIGHT]) * dim_now[REG_SRC_WIDTH]
           + c * dim_now[REG_SRC_WIDTH] / dim_now[REG_DST_WIDTH];
  endfunction

  task automatic issue(input scaler_cmd_e cmd, input logic [PIX_W-1:0] pix);
    int unsigned frame_pixels;
    frame_pixels = dim_now[REG_SRC_WIDTH] * dim_now[REG_SRC_HEIGHT];
    if (cmd == CMD_LOAD) begin
      if (loaded_pos >= frame_pixels) begin
        loaded_pos = 0;
      end
      loaded_pos++;
      if (loaded_pos > loaded_hi) begin
        loaded_hi = loaded_pos;
      end
      if (loaded_pos >= frame_pixels) begin
        loaded_pos = 0;
      end
    end else begin
      if (next_col >= dim_now[REG_DST_WIDTH]) begin
        next_col = 0;
      end
      if (next_row >= dim_now[REG_DST_HEIGHT]) begin
        next_row = 0;
      end
      next_col++;
      if (next_col >= dim_now[REG_DST_WIDTH]) begin
        next_col = 0;
        next_row++;
        if (next_row >= dim_now[REG_DST_HEIGHT]) begin
          next_row = 0;
        end
      end
    end
    in_valid <= 1'b1;
    command <= cmd;
    pixel_in <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Loads give no result, so the task waits on past the last pending output to let the last load land in the store.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input int unsigned vals [4], input bit [3:0] mask);
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_W'(i);
        cfg_data <= DIM_W'(vals[i]);
        @(posedge clk);
        dim_now[i] = effective_dim(vals[i],
            (i == REG_SRC_WIDTH || i == REG_DST_WIDTH) ? MAX_WIDTH : MAX_HEIGHT);
      end
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned vals [4];
    bit [3:0]    mask;
    int unsigned pick;
    int unsigned random_items;
    int unsigned phase;
    int unsigned budget;
    int unsigned fetch_pct;
    int unsigned gap_max;
    int unsigned pause_at;
    int          burst;
    bit          use_fetch;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A one-pixel-wide source column, stretched to the widest output row of height one.
    vals[REG_SRC_WIDTH] = 0;
    vals[REG_SRC_HEIGHT] = 3;
    vals[REG_DST_WIDTH] = 511;
    vals[REG_DST_HEIGHT] = 0;
    write_regs(vals, 4'b1111);
    issue(CMD_LOAD, 32'h0000_0000);
    issue(CMD_LOAD, 32'hFFFF_FFFF);
    issue(CMD_LOAD, 32'h5A5A_A5A5);
    repeat (3) issue(CMD_FETCH, $urandom);
    issue(CMD_LOAD, 32'h1234_5678);
    issue(CMD_FETCH, 32'hFFFF_FFFF);
    issue(CMD_LOAD, 32'hC3C3_3C3C);
    settle();

    // The source shrinks below the load position and the output column falls out of range.
    vals[REG_SRC_WIDTH] = 2;
    vals[REG_SRC_HEIGHT] = 1;
    vals[REG_DST_WIDTH] = 2;
    vals[REG_DST_HEIGHT] = 2;
    write_regs(vals, 4'b1111);
    issue(CMD_LOAD, $urandom);
    repeat (5) issue(CMD_FETCH, $urandom);
    settle();

    vals[REG_DST_WIDTH] = 1;
    vals[REG_DST_HEIGHT] = 1;
    mask = '0;
    mask[REG_DST_WIDTH] = 1'b1;
    mask[REG_DST_HEIGHT] = 1'b1;
    write_regs(vals, mask);
    repeat (2) issue(CMD_FETCH, $urandom);

    random_items = 0;
    phase = 0;
    while (random_items < 550) begin
      settle();
      for (int r = 0; r < 4; r++) begin
        pick = $urandom_range(0, 9);
        mask[r] = (pick != 3);
        case (pick)
          0: begin
            vals[r] = 0;
          end
          1: begin
            vals[r] = 256;
          end
          2: begin
            vals[r] = $urandom_range(257, 511);
          end
          default: begin
            vals[r] = (r == REG_SRC_WIDTH || r == REG_SRC_HEIGHT) ?
                      $urandom_range(1, 6) : $urandom_range(1, 9);
          end
        endcase
      end
      write_regs(vals, mask);

      budget = $urandom_range(20, 70);
      fetch_pct = $urandom_range(30, 85);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      pause_at = (phase == 0 || $urandom_range(0, 2) == 0) ?
                 $urandom_range(1, budget - 1) : budget;
      burst = $urandom_range(1, 16);
      for (int k = 0; k < budget; k++) begin
        if (k == pause_at) begin
          settle();
        end else if (burst <= 0) begin
          burst = $urandom_range(1, 16);
          if (gap_max != 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clk);
          end
        end
        use_fetch = (fetch_source() < loaded_hi) && ($urandom_range(1, 100) <= fetch_pct);
        issue(use_fetch ? CMD_FETCH : CMD_LOAD, $urandom);
        burst--;
        random_items++;
      end
      phase++;
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
